// ----- sv/assert_macros.svh -----
// assertion helpers included by the queue unit rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_PROP(label, clk, rstn, prop) \
	label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("property violated");

`define ASSERT_NEVER(label, clk, rstn, expr) \
	label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rstn, prop)

`define ASSERT_NEVER(label, clk, rstn, expr)

`endif

`endif

// ----- sv/prjq_pkg.sv -----
`default_nettype none

package prjq_pkg;

	localparam int QUEUE_DEPTH = 128;
	localparam int TAG_BITS    = 16;
	localparam int PRIO_BITS   = 8;

	localparam int IDX_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
	localparam int KEY_BITS    = PRIO_BITS + IDX_BITS;
	localparam int KB_BITS     = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
	localparam int OCC_BITS    = 8;
	localparam int STATUS_BITS = 2;

	localparam logic [STATUS_BITS-1:0] STATUS_DONE  = 2'd0;
	localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef logic [TAG_BITS-1:0]  tag_t;
	typedef logic [PRIO_BITS-1:0] prio_t;
	typedef logic [IDX_BITS-1:0]  idx_t;
	typedef logic [CNT_BITS-1:0]  cnt_t;
	typedef logic [KB_BITS-1:0]   key_idx_t;

	// broadcast to every cell
	typedef struct packed {
		logic     push_en;
		logic     cand_init;
		logic     search_en;
		logic     commit_en;
		key_idx_t key_bit;
		idx_t     head;
		idx_t     best_rel;
		idx_t     rot_amt;
		tag_t     push_tag;
		prio_t    push_prio;
		idx_t     push_seq;
	} ctl_t;

	// per-cell selects
	typedef struct packed {
		logic push_sel;
		logic live;
		logic shift_sel;
	} cell_sel_t;

endpackage

`default_nettype wire

// ----- sv/prjq_cell.sv -----
`default_nettype none

module prjq_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  prjq_pkg::ctl_t      ctl,
	input  prjq_pkg::cell_sel_t sel,
	input  logic                any_hit,
	input  prjq_pkg::tag_t      nb_tag,
	input  prjq_pkg::prio_t     nb_prio,
	input  prjq_pkg::idx_t      nb_seq,
	output prjq_pkg::tag_t      tag,
	output prjq_pkg::prio_t     prio,
	output prjq_pkg::idx_t      seq,
	output prjq_pkg::idx_t      adj_seq,
	output logic                hit,
	output logic                cand
);
	import prjq_pkg::*;

	tag_t                tag_q;
	prio_t               prio_q;
	idx_t                seq_q;
	logic                cand_q;
	idx_t                rel;
	logic [KEY_BITS-1:0] key;

	// position counted from the head
	assign rel = seq_q - ctl.head;
	// higher priority wins, then nearer the head
	assign key = {prio_q, ~rel};
	assign hit = cand_q & key[ctl.key_bit];
	// jobs ahead of the served one move behind the tail
	assign adj_seq = (rel < ctl.best_rel) ? (seq_q + ctl.rot_amt) : seq_q;

	assign tag  = tag_q;
	assign prio = prio_q;
	assign seq  = seq_q;
	assign cand = cand_q;

	always_ff @(posedge clk) begin
		if (ctl.push_en && sel.push_sel) begin
			tag_q  <= ctl.push_tag;
			prio_q <= ctl.push_prio;
			seq_q  <= ctl.push_seq;
		end else if (ctl.commit_en) begin
			if (sel.shift_sel) begin
				tag_q  <= nb_tag;
				prio_q <= nb_prio;
				seq_q  <= nb_seq;
			end else begin
				seq_q <= adj_seq;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= 1'b0;
		end else if (ctl.cand_init) begin
			cand_q <= sel.live;
		end else if (ctl.search_en && any_hit) begin
			cand_q <= hit;
		end
	end

endmodule

`default_nettype wire

// ----- sv/priority_rotating_job_queue_unit.sv -----
`default_nettype none
`include "assert_macros.svh"

// Priority job queue built as a row of cells, one job per cell.
// Command channel: an item (operation, job_tag, job_priority) is taken at a
// rising edge where start is high and busy is low. Busy stays high until the
// item's result is out; one item is worked on at a time.
// Result channel: done is high for exactly one cycle with status, served_tag,
// served_priority and occupancy. There is no backpressure: the receiver must
// take the result in that cycle. In the done cycle busy is already low, so the
// next start may be taken there.
// Steps: a push, or any refused item, is answered straight from the execute state.
// A successful pop runs a search step, a pick step and a commit step:
// the first-maximum search walks the priority and position key one bit per
// cycle as a wired-or over all cells, then the pick step registers the winner
// and the commit step shifts the cells above it down by one to close the gap.
// Rotation costs nothing extra: each cell keeps an order key and the entries
// ahead of the served one get their key moved past the tail in parallel.
// Reset clears the job count, the head key and the control state; cell
// contents stay undefined until pushed and are never read before that.
module priority_rotating_job_queue_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic                                 operation,
	input  prjq_pkg::tag_t                       job_tag,
	input  prjq_pkg::prio_t                      job_priority,
	output logic                                 busy,
	output logic                                 done,
	output logic [prjq_pkg::STATUS_BITS-1:0]     status,
	output prjq_pkg::tag_t                       served_tag,
	output prjq_pkg::prio_t                      served_priority,
	output logic [prjq_pkg::OCC_BITS-1:0]        occupancy
);
	import prjq_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EXEC   = 3'd1;
	localparam logic [2:0] S_SEARCH = 3'd2;
	localparam logic [2:0] S_PICK   = 3'd3;
	localparam logic [2:0] S_COMMIT = 3'd4;

	logic [2:0]             state_q;
	cnt_t                   count_q;
	idx_t                   head_q;
	key_idx_t               key_bit_q;
	logic                   done_q;

	logic                   op_q;
	tag_t                   tag_q;
	prio_t                  prio_q;
	idx_t                   best_idx_q;
	idx_t                   best_seq_q;
	tag_t                   best_tag_q;
	prio_t                  best_prio_q;
	logic [STATUS_BITS-1:0] status_q;
	tag_t                   served_tag_q;
	prio_t                  served_prio_q;
	logic [OCC_BITS-1:0]    occ_q;

	ctl_t                   ctl;
	cell_sel_t              sel_vec [QUEUE_DEPTH];
	tag_t                   tag_tap [QUEUE_DEPTH];
	prio_t                  prio_tap [QUEUE_DEPTH];
	idx_t                   seq_tap [QUEUE_DEPTH];
	idx_t                   adj_tap [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] hit_vec;
	logic [QUEUE_DEPTH-1:0] cand_vec;
	logic                   any_hit;
	logic                   is_full;
	logic                   is_empty;

	idx_t                   pick_idx;
	idx_t                   pick_seq;
	tag_t                   pick_tag;
	prio_t                  pick_prio;

	assign is_full  = (count_q == CNT_BITS'(QUEUE_DEPTH));
	assign is_empty = (count_q == '0);
	assign any_hit  = |hit_vec;

	always_comb begin
		ctl           = '0;
		ctl.push_en   = (state_q == S_EXEC) && (op_q == OP_PUSH) && !is_full;
		ctl.cand_init = (state_q == S_EXEC) && (op_q == OP_POP);
		ctl.search_en = (state_q == S_SEARCH);
		ctl.commit_en = (state_q == S_COMMIT);
		ctl.key_bit   = key_bit_q;
		ctl.head      = head_q;
		ctl.best_rel  = best_seq_q - head_q;
		ctl.rot_amt   = IDX_BITS'(count_q);
		ctl.push_tag  = tag_q;
		ctl.push_prio = prio_q;
		ctl.push_seq  = head_q + IDX_BITS'(count_q);
	end

	genvar gi;
	generate
		for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
			assign sel_vec[gi].push_sel  = (IDX_BITS'(count_q) == IDX_BITS'(gi));
			assign sel_vec[gi].live      = (CNT_BITS'(gi) < count_q);
			assign sel_vec[gi].shift_sel = (IDX_BITS'(gi) >= best_idx_q);

			if (gi < QUEUE_DEPTH - 1) begin : g_mid
				prjq_cell u_cell (
					.clk     (clk),
					.arst_n  (arst_n),
					.ctl     (ctl),
					.sel     (sel_vec[gi]),
					.any_hit (any_hit),
					.nb_tag  (tag_tap[gi+1]),
					.nb_prio (prio_tap[gi+1]),
					.nb_seq  (adj_tap[gi+1]),
					.tag     (tag_tap[gi]),
					.prio    (prio_tap[gi]),
					.seq     (seq_tap[gi]),
					.adj_seq (adj_tap[gi]),
					.hit     (hit_vec[gi]),
					.cand    (cand_vec[gi])
				);
			end else begin : g_last
				prjq_cell u_cell (
					.clk     (clk),
					.arst_n  (arst_n),
					.ctl     (ctl),
					.sel     (sel_vec[gi]),
					.any_hit (any_hit),
					.nb_tag  ('0),
					.nb_prio ('0),
					.nb_seq  ('0),
					.tag     (tag_tap[gi]),
					.prio    (prio_tap[gi]),
					.seq     (seq_tap[gi]),
					.adj_seq (adj_tap[gi]),
					.hit     (hit_vec[gi]),
					.cand    (cand_vec[gi])
				);
			end
		end
	endgenerate

	// one candidate is left after the search
	always_comb begin
		pick_idx  = '0;
		pick_seq  = '0;
		pick_tag  = '0;
		pick_prio = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (cand_vec[i]) begin
				pick_idx  = pick_idx | IDX_BITS'(i);
				pick_seq  = pick_seq | seq_tap[i];
				pick_tag  = pick_tag | tag_tap[i];
				pick_prio = pick_prio | prio_tap[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			head_q    <= '0;
			key_bit_q <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (op_q == OP_PUSH) begin
						if (!is_full) begin
							count_q <= count_q + CNT_BITS'(1);
						end
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (is_empty) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						key_bit_q <= KB_BITS'(KEY_BITS - 1);
						state_q   <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (key_bit_q == '0) begin
						state_q <= S_PICK;
					end else begin
						key_bit_q <= key_bit_q - KB_BITS'(1);
					end
				end
				S_PICK: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					count_q <= count_q - CNT_BITS'(1);
					head_q  <= best_seq_q + IDX_BITS'(1);
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && start) begin
			op_q   <= operation;
			tag_q  <= job_tag;
			prio_q <= job_priority;
		end
		if (state_q == S_PICK) begin
			best_idx_q  <= pick_idx;
			best_seq_q  <= pick_seq;
			best_tag_q  <= pick_tag;
			best_prio_q <= pick_prio;
		end
		if (state_q == S_EXEC) begin
			served_tag_q  <= '0;
			served_prio_q <= '0;
			if (op_q == OP_PUSH) begin
				if (is_full) begin
					status_q <= STATUS_FULL;
					occ_q    <= OCC_BITS'(count_q);
				end else begin
					status_q <= STATUS_DONE;
					occ_q    <= OCC_BITS'(count_q + CNT_BITS'(1));
				end
			end else begin
				status_q <= STATUS_EMPTY;
				occ_q    <= OCC_BITS'(count_q);
			end
		end
		if (state_q == S_COMMIT) begin
			status_q      <= STATUS_DONE;
			served_tag_q  <= best_tag_q;
			served_prio_q <= best_prio_q;
			occ_q         <= OCC_BITS'(count_q - CNT_BITS'(1));
		end
	end

	assign busy            = (state_q != S_IDLE);
	assign done            = done_q;
	assign status          = status_q;
	assign served_tag      = served_tag_q;
	assign served_priority = served_prio_q;
	assign occupancy       = occ_q;

	`ASSERT_NEVER(a_count_range, clk, arst_n, count_q > CNT_BITS'(QUEUE_DEPTH))
	`ASSERT_PROP(a_pick_onehot, clk, arst_n, (state_q == S_PICK) |-> $onehot(cand_vec))
	`ASSERT_PROP(a_done_source, clk, arst_n, done_q |-> (($past(state_q) == S_EXEC) || ($past(state_q) == S_COMMIT)))
	`ASSERT_PROP(a_pop_count, clk, arst_n, (state_q == S_COMMIT) |=> (count_q == ($past(count_q) - CNT_BITS'(1))))

endmodule

`default_nettype wire
